// File: rtl/rsp_pkg.sv
// Package for the Reed-Solomon parity encoder: register indexes, reset values,
// the GF(256) multiply and the configuration struct. No dependencies.
`default_nettype none
package rsp_pkg;

  localparam int MAX_PARITY_DEF = 30;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_PARITY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIM_POLY    = 2'd1;

  localparam logic [4:0] PARITY_COUNT_RST = 5'd10;
  localparam logic [8:0] PRIM_POLY_RST    = 9'd285;

  typedef struct packed {
    logic [4:0] parity_count;
    logic [7:0] red;
  } rsp_cfg_t;

  // Shift-and-add multiply, reduced by the low byte of the field polynomial.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] red);
    logic [7:0] x;
    logic [7:0] r;
    x = a;
    r = 8'd0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r = r ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? red : 8'd0);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rsp_if.sv
// Channel interfaces of the parity encoder: message bytes in, parity bytes out.
// No dependencies.
`default_nettype none
interface rsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic       parity_last;
  modport source (output valid, output parity_byte, output parity_last, input ready);
  modport sink   (input valid, input parity_byte, input parity_last, output ready);
endinterface
`default_nettype wire

// File: rtl/rsp_gen.sv
// Configuration registers and generator polynomial sequencer, one root a cycle.
// Depends on rsp_pkg.
`default_nettype none
module rsp_gen #(
  parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF,
  parameter int NW = $clog2(MAX_PARITY + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                busy,
  output logic                                restart,
  output logic [NW-1:0]                       n_act,
  output logic [7:0]                          red,
  output logic [MAX_PARITY:0][7:0]            gen_coeffs
);
  import rsp_pkg::*;

  rsp_cfg_t                cfg_r;
  logic                    busy_r;
  logic [NW-1:0]           iter_r;
  logic [7:0]              root_r;
  logic [MAX_PARITY:0][7:0] g_r;
  logic                    hit;

  assign hit     = cfg_we && (cfg_idx == REG_PARITY_COUNT || cfg_idx == REG_PRIM_POLY);
  assign restart = hit;

  always_comb begin
    if (cfg_r.parity_count == 5'd0) begin
      n_act = NW'(1);
    end else if (int'(cfg_r.parity_count) > MAX_PARITY) begin
      n_act = NW'(MAX_PARITY);
    end else begin
      n_act = NW'(cfg_r.parity_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.parity_count <= PARITY_COUNT_RST;
      cfg_r.red          <= PRIM_POLY_RST[7:0];
      busy_r             <= 1'b1;
      iter_r             <= '0;
      root_r             <= 8'd1;
      g_r                <= {{MAX_PARITY{8'd0}}, 8'd1};
    end else if (hit) begin
      if (cfg_idx == REG_PARITY_COUNT) cfg_r.parity_count <= cfg_data[4:0];
      else                             cfg_r.red          <= cfg_data[7:0];
      busy_r <= 1'b1;
      iter_r <= '0;
      root_r <= 8'd1;
      g_r    <= {{MAX_PARITY{8'd0}}, 8'd1};
    end else if (busy_r) begin
      if (iter_r == n_act) begin
        busy_r <= 1'b0;
      end else begin
        // multiply in (x - root): every coefficient from the old set at once
        for (int j = 1; j <= MAX_PARITY; j++) begin
          g_r[j] <= g_r[j] ^ gf_mul(g_r[j-1], root_r, cfg_r.red);
        end
        root_r <= gf_mul(root_r, 8'd2, cfg_r.red);
        iter_r <= iter_r + NW'(1);
      end
    end
  end

  assign busy       = busy_r;
  assign red        = cfg_r.red;
  assign gen_coeffs = g_r;

endmodule
`default_nettype wire

// File: rtl/rsp_front.sv
// Front end: accepts message bytes and runs the parallel division LFSR.
// Depends on rsp_pkg and rsp_if.
`default_nettype none
module rsp_front #(
  parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF,
  parameter int NW = $clog2(MAX_PARITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rsp_in_if.sink                             in_ch,
  input  wire logic                          gen_busy,
  input  wire logic                          restart,
  input  wire logic [7:0]                    red,
  input  wire logic [MAX_PARITY:0][7:0]      gen_coeffs,
  input  wire logic                          q_ready,
  output logic                               q_push,
  output logic [MAX_PARITY-1:0][7:0]         q_rem
);
  import rsp_pkg::*;

  logic [MAX_PARITY-1:0][7:0] rem_r;
  logic [MAX_PARITY-1:0][7:0] rem_nxt;
  logic [7:0]                 fb;
  logic                       acc;

  assign in_ch.ready = !gen_busy && q_ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign fb          = in_ch.data_byte ^ rem_r[0];

  // entries above the active degree stay zero, as do their coefficients
  always_comb begin
    for (int j = 0; j < MAX_PARITY; j++) begin
      if (j < MAX_PARITY - 1) rem_nxt[j] = rem_r[j+1] ^ gf_mul(fb, gen_coeffs[j+1], red);
      else                    rem_nxt[j] = gf_mul(fb, gen_coeffs[j+1], red);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      rem_r <= '0;
    end else if (acc) begin
      rem_r <= in_ch.last_byte ? '0 : rem_nxt;
    end
  end

  assign q_push = acc && in_ch.last_byte;
  assign q_rem  = rem_nxt;

endmodule
`default_nettype wire

// File: rtl/rsp_queue.sv
// Two-entry queue of finished remainders between front and back end.
// Depends on rsp_pkg.
`default_nettype none
module rsp_queue #(
  parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire logic [MAX_PARITY-1:0][7:0]    push_rem,
  output logic                               can_push,
  input  wire logic                          pop,
  output logic                               not_empty,
  output logic [MAX_PARITY-1:0][7:0]         head_rem
);
  import rsp_pkg::*;

  logic [MAX_PARITY-1:0][7:0] ent_r [2];
  logic                       wp_r;
  logic                       rp_r;
  logic [1:0]                 cnt_r;

  assign can_push  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head_rem  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/rsp_back.sv
// Back end: loads a remainder block and shifts it out, one parity byte a transfer.
// Depends on rsp_pkg and rsp_if.
`default_nettype none
module rsp_back #(
  parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF,
  parameter int NW = $clog2(MAX_PARITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rsp_out_if.source                          out_ch,
  input  wire logic [NW-1:0]                 n_act,
  input  wire logic                          q_not_empty,
  input  wire logic [MAX_PARITY-1:0][7:0]    q_head,
  output logic                               q_pop
);
  import rsp_pkg::*;

  logic [MAX_PARITY-1:0][7:0] sh_r;
  logic [NW-1:0]              idx_r;
  logic                       act_r;
  logic                       is_last;
  logic                       take;

  assign is_last = (idx_r == n_act - NW'(1));
  assign take    = act_r && out_ch.ready;
  assign q_pop   = q_not_empty && (!act_r || (take && is_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= '0;
    end else if (q_pop) begin
      act_r <= 1'b1;
      idx_r <= '0;
    end else if (take) begin
      if (is_last) act_r <= 1'b0;
      idx_r <= idx_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sh_r <= q_head;
    end else if (take) begin
      sh_r <= {8'd0, sh_r[MAX_PARITY-1:1]};
    end
  end

  assign out_ch.valid       = act_r;
  assign out_ch.parity_byte = sh_r[0];
  assign out_ch.parity_last = is_last;

endmodule
`default_nettype wire

// File: rtl/reed_solomon_parity_encoder.sv
// Channel  | Direction | Handshake      | Payload
// in_ch    | in        | valid/ready    | data_byte[7:0], last_byte
// out_ch   | out       | valid/ready    | parity_byte[7:0], parity_last
// cfg_*    | in        | cfg_we         | cfg_idx[1:0], cfg_data[8:0]
//
// One message byte a cycle while in_ch.ready is high; the LFSR updates every
// remainder byte at once. After reset or a register write the generator is
// built one root a cycle, in_ch.ready low until done. Each message yields n
// parity bytes, n the active parity count, one per cycle while out_ch.ready
// is high, from the back-end shift register; a two-block queue lets the next
// message in and stalls the input when full. Reset is synchronous, active low.
`default_nettype none
module reed_solomon_parity_encoder #(
  parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rsp_in_if.sink                              in_ch,
  rsp_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rsp_pkg::*;

  localparam int NW = $clog2(MAX_PARITY + 1);

  logic                       gen_busy;
  logic                       restart;
  logic [NW-1:0]              n_act;
  logic [7:0]                 red;
  logic [MAX_PARITY:0][7:0]   gen_coeffs;
  logic                       q_push;
  logic                       q_can_push;
  logic                       q_pop;
  logic                       q_not_empty;
  logic [MAX_PARITY-1:0][7:0] q_in;
  logic [MAX_PARITY-1:0][7:0] q_head;

  rsp_gen #(.MAX_PARITY(MAX_PARITY), .NW(NW)) u_gen (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .busy(gen_busy), .restart, .n_act, .red, .gen_coeffs
  );

  rsp_front #(.MAX_PARITY(MAX_PARITY), .NW(NW)) u_front (
    .clk, .rst_n, .in_ch, .gen_busy, .restart, .red, .gen_coeffs,
    .q_ready(q_can_push), .q_push, .q_rem(q_in)
  );

  rsp_queue #(.MAX_PARITY(MAX_PARITY)) u_queue (
    .clk, .rst_n, .push(q_push), .push_rem(q_in), .can_push(q_can_push),
    .pop(q_pop), .not_empty(q_not_empty), .head_rem(q_head)
  );

  rsp_back #(.MAX_PARITY(MAX_PARITY), .NW(NW)) u_back (
    .clk, .rst_n, .out_ch, .n_act, .q_not_empty, .q_head, .q_pop
  );

endmodule
`default_nettype wire

// File: rtl/rsp_chk.sv
// Port-level checks for the parity encoder, bound to the top level.
// Depends on rsp_pkg and reed_solomon_parity_encoder.
`default_nettype none
module rsp_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [7:0]                    out_byte,
  input wire logic                          out_last,
  input wire logic                          cfg_we,
  input wire logic [rsp_pkg::CFG_IDX_W-1:0] cfg_idx
);
  import rsp_pkg::*;

  // generator is rebuilt after reset: no transfer in the next cycle
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready straight after reset");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_idx == REG_PARITY_COUNT || cfg_idx == REG_PRIM_POLY) |=> !in_ready)
    else $error("input ready straight after register write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled parity byte changed");

endmodule

bind reed_solomon_parity_encoder rsp_chk u_rsp_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_byte(out_ch.parity_byte),
  .out_last(out_ch.parity_last), .cfg_we(cfg_we), .cfg_idx(cfg_idx)
);
`default_nettype wire
